### sv/bbcl_pkg.sv
// Shared types and constants for the bounded best-candidate list.
package bbcl_pkg;

	localparam int TABLE_DEPTH_DEF = 8;

	localparam logic [7:0]  ID_NONE    = 8'hFF;
	localparam logic [15:0] SCORE_ZERO = 16'h0000;
	localparam logic [15:0] SCORE_MAX  = 16'hFFFF;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_RANK,
		S_DONE
	} seq_state_t;

	// running result handed from cell to cell
	typedef struct packed {
		logic        found;
		logic [15:0] hit_score;
		logic [15:0] min_score;
		logic [15:0] best_score;
		logic [7:0]  best_id;
	} acc_t;

	// entry write broadcast from the sequencer
	typedef struct packed {
		logic        en;
		logic [7:0]  id;
		logic [15:0] score;
		logic [23:0] power;
	} wr_t;

	localparam acc_t ACC_INIT = '{
		found:      1'b0,
		hit_score:  SCORE_ZERO,
		min_score:  SCORE_MAX,
		best_score: SCORE_ZERO,
		best_id:    ID_NONE
	};

endpackage

### sv/bbcl_cell.sv
// One table entry plus its stage of the search chain.
module bbcl_cell #(
	parameter int TABLE_DEPTH = 8,
	parameter int CELL_INDEX  = 0,
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      key_id,
	input  logic [CW-1:0]   count,
	input  bbcl_pkg::wr_t   wr,
	input  logic [IW-1:0]   wr_idx,
	input  logic            tok_in,
	input  bbcl_pkg::acc_t  acc_in,
	input  logic [IW-1:0]   hit_idx_in,
	input  logic [IW-1:0]   min_idx_in,
	output logic            tok_out,
	output bbcl_pkg::acc_t  acc_out,
	output logic [IW-1:0]   hit_idx_out,
	output logic [IW-1:0]   min_idx_out
);
	import bbcl_pkg::*;

	logic [7:0]    id_q;
	logic [15:0]   score_q;
	logic [23:0]   power_q;
	logic          tok_q;
	acc_t          acc_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] min_idx_q;

	logic          held;
	acc_t          acc_d;
	logic [IW-1:0] hit_idx_d;
	logic [IW-1:0] min_idx_d;

	assign held = CW'(CELL_INDEX) < count;

	always_comb begin
		acc_d     = acc_in;
		hit_idx_d = hit_idx_in;
		min_idx_d = min_idx_in;
		if (held && (id_q == key_id) && !acc_in.found) begin
			acc_d.found     = 1'b1;
			acc_d.hit_score = score_q;
			hit_idx_d       = IW'(CELL_INDEX);
		end
		if (held && (score_q < acc_in.min_score)) begin
			acc_d.min_score = score_q;
			min_idx_d       = IW'(CELL_INDEX);
		end
		if (held && (score_q > acc_in.best_score)) begin
			acc_d.best_score = score_q;
			acc_d.best_id    = id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		acc_q     <= acc_d;
		hit_idx_q <= hit_idx_d;
		min_idx_q <= min_idx_d;
		if (wr.en && (wr_idx == IW'(CELL_INDEX))) begin
			id_q    <= wr.id;
			score_q <= wr.score;
			power_q <= wr.power;
		end
	end

	assign tok_out     = tok_q;
	assign acc_out     = acc_q;
	assign hit_idx_out = hit_idx_q;
	assign min_idx_out = min_idx_q;

endmodule

### sv/bbcl_seq.sv
// Sequencer: item capture, two passes over the chain, entry update and result register.
module bbcl_seq #(
	parameter int TABLE_DEPTH = 8,
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic signed [7:0]  cand_id,
	input  logic [15:0]        score,
	input  logic signed [23:0] power_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               was_listed,
	output logic signed [7:0]  best_id,
	output logic [15:0]        best_score,
	output logic [3:0]         entry_count,
	output logic               launch,
	output logic [7:0]         key_id,
	output logic [CW-1:0]      count,
	output bbcl_pkg::wr_t      wr,
	output logic [IW-1:0]      wr_idx,
	input  logic               tok_last,
	input  bbcl_pkg::acc_t     acc_last,
	input  logic [IW-1:0]      hit_idx_last,
	input  logic [IW-1:0]      min_idx_last
);
	import bbcl_pkg::*;

	seq_state_t    state_q, state_d;
	logic          launch_q;
	logic          cmd_q;
	logic [7:0]    id_q;
	logic [15:0]   score_q;
	logic [23:0]   power_q;
	logic [CW-1:0] count_q;
	logic          found_q;
	logic [15:0]   hit_score_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] min_idx_q;
	logic [7:0]    rank_id_q;
	logic [15:0]   rank_score_q;
	logic          out_valid_q;
	logic          was_listed_q;
	logic [7:0]    best_id_q;
	logic [15:0]   best_score_q;
	logic [3:0]    entry_count_q;

	logic          in_take;
	logic          out_free;
	logic          do_update;
	logic          do_load;
	logic [CW-1:0] count_d;
	logic [CW+3:0] count_ext;

	assign in_take  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_SCAN;
			S_SCAN:   if (tok_last) state_d = S_UPDATE;
			S_UPDATE: state_d = S_RANK;
			S_RANK:   if (tok_last) state_d = S_DONE;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		do_update = 1'b0;
		do_load   = 1'b0;
		unique case (state_q)
			S_IDLE:   in_ready  = 1'b1;
			S_SCAN:   ;
			S_UPDATE: do_update = 1'b1;
			S_RANK:   ;
			S_DONE:   do_load   = out_free;
			default:  ;
		endcase
	end

	always_comb begin
		wr.en    = 1'b0;
		wr.id    = id_q;
		wr.score = score_q;
		wr.power = power_q;
		wr_idx   = min_idx_q;
		count_d  = count_q;
		priority if (cmd_q == CMD_CLEAR) begin
			count_d = '0;
		end else if (found_q) begin
			wr.en  = hit_score_q < score_q;
			wr_idx = hit_idx_q;
		end else if (count_q != CW'(TABLE_DEPTH)) begin
			wr.en   = 1'b1;
			wr_idx  = count_q[IW-1:0];
			count_d = count_q + CW'(1);
		end else begin
			wr.en  = 1'b1;
			wr_idx = min_idx_q;
		end
		wr.en = wr.en && do_update;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= in_take || do_update;
			if (do_update) begin
				count_q <= count_d;
			end
			if (do_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign count_ext = {4'b0000, count_q};

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q   <= command;
			id_q    <= cand_id;
			score_q <= score;
			power_q <= power_value;
		end
		if (state_q == S_SCAN && tok_last) begin
			found_q     <= acc_last.found;
			hit_score_q <= acc_last.hit_score;
			hit_idx_q   <= hit_idx_last;
			min_idx_q   <= min_idx_last;
		end
		if (state_q == S_RANK && tok_last) begin
			rank_id_q    <= acc_last.best_id;
			rank_score_q <= acc_last.best_score;
		end
		if (do_load) begin
			was_listed_q  <= found_q;
			best_id_q     <= rank_id_q;
			best_score_q  <= rank_score_q;
			entry_count_q <= count_ext[3:0];
		end
	end

	assign launch      = launch_q;
	assign key_id      = id_q;
	assign count       = count_q;
	assign out_valid   = out_valid_q;
	assign was_listed  = was_listed_q;
	assign best_id     = best_id_q;
	assign best_score  = best_score_q;
	assign entry_count = entry_count_q;

endmodule

### sv/bounded_best_candidate_list.sv
// Top level of the bounded best-candidate list.
// Each entry lives in its own cell of a chain; a token walks the chain once to find the
// id and the lowest-score victim, the sequencer then writes at most one entry, and a
// second walk finds the best entry; each walk moves one cell per cycle. A new transaction
// is accepted once the previous result has moved to the output register.
// Entries past the fill count are never read, so no clearing is done after reset.
module bounded_best_candidate_list #(
	parameter int TABLE_DEPTH = bbcl_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic signed [7:0]  cand_id,
	input  logic [15:0]        score,
	input  logic signed [23:0] power_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               was_listed,
	output logic signed [7:0]  best_id,
	output logic [15:0]        best_score,
	output logic [3:0]         entry_count
);
	import bbcl_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic          launch;
	logic [7:0]    key_id;
	logic [CW-1:0] count;
	wr_t           wr;
	logic [IW-1:0] wr_idx;

	logic          tok     [TABLE_DEPTH+1];
	acc_t          acc     [TABLE_DEPTH+1];
	logic [IW-1:0] hit_idx [TABLE_DEPTH+1];
	logic [IW-1:0] min_idx [TABLE_DEPTH+1];

	assign tok[0]     = launch;
	assign acc[0]     = ACC_INIT;
	assign hit_idx[0] = '0;
	assign min_idx[0] = '0;

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		bbcl_cell #(
			.TABLE_DEPTH (TABLE_DEPTH),
			.CELL_INDEX  (k)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.key_id      (key_id),
			.count       (count),
			.wr          (wr),
			.wr_idx      (wr_idx),
			.tok_in      (tok[k]),
			.acc_in      (acc[k]),
			.hit_idx_in  (hit_idx[k]),
			.min_idx_in  (min_idx[k]),
			.tok_out     (tok[k+1]),
			.acc_out     (acc[k+1]),
			.hit_idx_out (hit_idx[k+1]),
			.min_idx_out (min_idx[k+1])
		);
	end

	bbcl_seq #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.cand_id      (cand_id),
		.score        (score),
		.power_value  (power_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.was_listed   (was_listed),
		.best_id      (best_id),
		.best_score   (best_score),
		.entry_count  (entry_count),
		.launch       (launch),
		.key_id       (key_id),
		.count        (count),
		.wr           (wr),
		.wr_idx       (wr_idx),
		.tok_last     (tok[TABLE_DEPTH]),
		.acc_last     (acc[TABLE_DEPTH]),
		.hit_idx_last (hit_idx[TABLE_DEPTH]),
		.min_idx_last (min_idx[TABLE_DEPTH])
	);

endmodule
